@@ rtl/assert_macros.svh @@
// Assertion helpers for the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MFD_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/mfd_pkg.sv @@
package mfd_pkg;

  localparam int FRAME_BYTES = 9;
  // Bytes 1..7 are stored; byte 8 is checked as it arrives.
  localparam int STORE_DEPTH = FRAME_BYTES - 2;
  localparam int POS_W       = $clog2(STORE_DEPTH + 1);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 2);
  localparam logic [7:0] SYNC_RESET = 8'hAA;

  typedef logic [7:0] byte_t;

  typedef struct packed {
    logic        frame_ok;
    logic        linear_move;
    logic        dir_x;
    logic        dir_y;
    logic        dir_z;
    logic [15:0] steps_x;
    logic [15:0] steps_y;
    logic [15:0] steps_z;
    byte_t       flag_byte;
    byte_t       check_byte;
  } mfd_result_t;

  typedef struct packed {
    logic in_frame;
    logic last_pos;
  } mfd_stat_t;

endpackage

@@ rtl/mfd_ifs.sv @@
interface mfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface mfd_out_if;
  logic        valid;
  logic        ready;
  logic        frame_ok;
  logic        linear_move;
  logic        dir_x;
  logic        dir_y;
  logic        dir_z;
  logic [15:0] steps_x;
  logic [15:0] steps_y;
  logic [15:0] steps_z;
  logic [7:0]  flag_byte;
  logic [7:0]  check_byte;

  modport source (output valid, output frame_ok, output linear_move, output dir_x,
                  output dir_y, output dir_z, output steps_x, output steps_y,
                  output steps_z, output flag_byte, output check_byte, input ready);
  modport sink (input valid, input frame_ok, input linear_move, input dir_x,
                input dir_y, input dir_z, input steps_x, input steps_y,
                input steps_z, input flag_byte, input check_byte, output ready);
endinterface

@@ rtl/mfd_collect.sv @@
module mfd_collect import mfd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  byte_t       cfg_data,
  input  logic        accept,
  input  byte_t       rx_byte,
  output mfd_stat_t   stat,
  output logic        done,
  output mfd_result_t result
);

  byte_t            sync_r;
  logic             in_frame_r, in_frame_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  byte_t            store_r [STORE_DEPTH];
  byte_t            chk;

  assign stat.in_frame = in_frame_r;
  assign stat.last_pos = in_frame_r && (pos_r == LAST_POS);
  assign done          = accept && stat.last_pos;

  always_comb begin
    in_frame_nxt = in_frame_r;
    pos_nxt      = pos_r;
    if (accept) begin
      if (!in_frame_r) begin
        if (rx_byte == sync_r) begin
          in_frame_nxt = 1'b1;
          pos_nxt      = '0;
        end
      end else if (pos_r == LAST_POS) begin
        in_frame_nxt = 1'b0;
        pos_nxt      = '0;
      end else begin
        pos_nxt = pos_r + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r     <= SYNC_RESET;
      in_frame_r <= 1'b0;
      pos_r      <= '0;
    end else begin
      if (cfg_we) begin
        sync_r <= cfg_data;
      end
      in_frame_r <= in_frame_nxt;
      pos_r      <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_frame_r && (pos_r != LAST_POS)) begin
      store_r[pos_r] <= rx_byte;
    end
  end

  always_comb begin
    chk = '0;
    for (int k = 0; k < STORE_DEPTH; k++) begin
      chk = chk ^ store_r[k];
    end
  end

  // The incoming byte is the checksum byte when the frame completes.
  always_comb begin
    result.frame_ok    = (chk == rx_byte);
    result.linear_move = store_r[0][0];
    result.dir_x       = store_r[0][1];
    result.dir_y       = store_r[0][2];
    result.dir_z       = store_r[0][3];
    result.steps_x     = {store_r[2], store_r[1]};
    result.steps_y     = {store_r[4], store_r[3]};
    result.steps_z     = {store_r[6], store_r[5]};
    result.flag_byte   = store_r[0];
    result.check_byte  = rx_byte;
  end

endmodule

@@ rtl/mfd_outreg.sv @@
module mfd_outreg import mfd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  mfd_result_t load_data,
  input  logic        out_ready,
  output logic        out_valid,
  output mfd_result_t out_data
);

  logic        valid_r, valid_nxt;
  mfd_result_t data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

@@ rtl/motion_frame_deframer_core.sv @@
// A result appears in the cycle after the request carrying frame byte 8.
// Throughput: one byte request per cycle; a waiting result only holds off the
// byte that would complete the next frame, set by the single output register.
// Reset (rst_n low at a clock edge): hunting for sync, no result pending,
// sync value back to 0xAA. Stored frame bytes are not cleared.
`include "assert_macros.svh"

module motion_frame_deframer_core import mfd_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [7:0]   cfg_data,
  mfd_in_if.sink       in_ch,
  mfd_out_if.source    out_ch
);

  mfd_stat_t   stat;
  logic        accept;
  logic        done;
  mfd_result_t result;
  mfd_result_t out_data;
  logic        out_valid;

  // Only the byte that would finish a frame must wait for the output register.
  assign in_ch.ready = !(stat.last_pos && out_valid && !out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;

  mfd_collect u_collect (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .accept   (accept),
    .rx_byte  (in_ch.rx_byte),
    .stat     (stat),
    .done     (done),
    .result   (result)
  );

  mfd_outreg u_outreg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (done),
    .load_data (result),
    .out_ready (out_ch.ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  assign out_ch.valid       = out_valid;
  assign out_ch.frame_ok    = out_data.frame_ok;
  assign out_ch.linear_move = out_data.linear_move;
  assign out_ch.dir_x       = out_data.dir_x;
  assign out_ch.dir_y       = out_data.dir_y;
  assign out_ch.dir_z       = out_data.dir_z;
  assign out_ch.steps_x     = out_data.steps_x;
  assign out_ch.steps_y     = out_data.steps_y;
  assign out_ch.steps_z     = out_data.steps_z;
  assign out_ch.flag_byte   = out_data.flag_byte;
  assign out_ch.check_byte  = out_data.check_byte;

  // A finished frame never overwrites a result that has not been taken.
  `MFD_ASSERT_SAME(a_no_overwrite, clk, rst_n, done, (!out_valid || out_ch.ready))
  // After the last byte the collector is hunting again.
  `MFD_ASSERT_NEXT(a_hunt_after_done, clk, rst_n, done, (!stat.in_frame))
  // A new result shows up only after a frame completed.
  `MFD_ASSERT_SAME(a_valid_from_done, clk, rst_n, $rose(out_valid), $past(done))

endmodule

@@ dv/mfd_frame_checker.sv @@
`timescale 1ns / 1ps

module mfd_frame_checker import mfd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data,
  mfd_in_if          in_mon,
  mfd_out_if         out_mon,
  output int         mismatches,
  output int         pending,
  output int         bytes_taken,
  output int         frames_seen,
  output int         frames_rejected
);

  byte_t       sync_q;
  bit          in_frame_q;
  int          taken;
  byte_t       frame_bytes [8];
  mfd_result_t expected_frames [$];
  int          shown;

  // Walks one accepted byte through the framing state; a completed frame
  // queues the decoded result it should produce.
  task automatic decode_byte(input byte_t b);
    mfd_result_t r;
    byte_t       sum;
    int          k;
    if (!in_frame_q) begin
      if (b == sync_q) begin
        in_frame_q = 1'b1;
        taken = 0;
      end
    end else begin
      frame_bytes[taken] = b;
      taken++;
      if (taken == 8) begin
        in_frame_q = 1'b0;
        taken = 0;
        sum = '0;
        for (k = 0; k < 7; k++) sum ^= frame_bytes[k];
        r.frame_ok    = (sum == frame_bytes[7]);
        r.linear_move = frame_bytes[0][0];
        r.dir_x       = frame_bytes[0][1];
        r.dir_y       = frame_bytes[0][2];
        r.dir_z       = frame_bytes[0][3];
        r.steps_x     = {frame_bytes[2], frame_bytes[1]};
        r.steps_y     = {frame_bytes[4], frame_bytes[3]};
        r.steps_z     = {frame_bytes[6], frame_bytes[5]};
        r.flag_byte   = frame_bytes[0];
        r.check_byte  = frame_bytes[7];
        expected_frames.push_back(r);
      end
    end
  endtask

  task automatic compare_field(input string label, input logic [15:0] want_v,
                               input logic [15:0] got_v, inout bit bad);
    if (got_v !== want_v) begin
      bad = 1'b1;
      if (shown < 10)
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $realtime, label,
                 want_v, got_v);
      shown++;
    end
  endtask

  always @(posedge clk) begin
    mfd_result_t got;
    mfd_result_t want;
    bit          bad;
    if (!rst_n) begin
      sync_q = SYNC_RESET;
      in_frame_q = 1'b0;
      taken = 0;
      expected_frames.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        decode_byte(in_mon.rx_byte);
        bytes_taken++;
      end
      if (out_mon.valid && out_mon.ready) begin
        got.frame_ok    = out_mon.frame_ok;
        got.linear_move = out_mon.linear_move;
        got.dir_x       = out_mon.dir_x;
        got.dir_y       = out_mon.dir_y;
        got.dir_z       = out_mon.dir_z;
        got.steps_x     = out_mon.steps_x;
        got.steps_y     = out_mon.steps_y;
        got.steps_z     = out_mon.steps_z;
        got.flag_byte   = out_mon.flag_byte;
        got.check_byte  = out_mon.check_byte;
        if (expected_frames.size() == 0) begin
          mismatches++;
          if (shown < 10)
            $display("%0t: result request with no frame outstanding", $realtime);
          shown++;
        end else begin
          want = expected_frames.pop_front();
          bad = 1'b0;
          compare_field("frame_ok", 16'(want.frame_ok), 16'(got.frame_ok), bad);
          compare_field("linear_move", 16'(want.linear_move), 16'(got.linear_move), bad);
          compare_field("dir_x", 16'(want.dir_x), 16'(got.dir_x), bad);
          compare_field("dir_y", 16'(want.dir_y), 16'(got.dir_y), bad);
          compare_field("dir_z", 16'(want.dir_z), 16'(got.dir_z), bad);
          compare_field("steps_x", want.steps_x, got.steps_x, bad);
          compare_field("steps_y", want.steps_y, got.steps_y, bad);
          compare_field("steps_z", want.steps_z, got.steps_z, bad);
          compare_field("flag_byte", 16'(want.flag_byte), 16'(got.flag_byte), bad);
          compare_field("check_byte", 16'(want.check_byte), 16'(got.check_byte), bad);
          if (bad) mismatches++;
          frames_seen++;
          if (!want.frame_ok) frames_rejected++;
        end
      end
      // A write lands after any byte taken on the same edge was judged.
      if (cfg_we) sync_q = cfg_data;
    end
    pending = expected_frames.size();
  end

endmodule

@@ dv/motion_frame_deframer_core_tb.sv @@
`timescale 1ns / 1ps

module motion_frame_deframer_core_tb import mfd_pkg::*; ();

  typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_PATTERN} rx_mode_t;

  localparam int IDLE_LIMIT  = 2000;
  localparam int HOLD_CYCLES = 80;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic [7:0] cfg_data;

  mfd_in_if  in_ch ();
  mfd_out_if out_ch ();

  int mismatches;
  int pending;
  int bytes_taken;
  int frames_seen;
  int frames_rejected;

  int       bytes_offered;
  int       burst_left;
  bit       dense;
  bit       hold_req;
  int       hold_count;
  int       rx_cyc;
  int       idle_cycles;
  rx_mode_t rx_mode;
  byte_t    sync_setting;
  byte_t    random_sync;

  motion_frame_deframer_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  mfd_frame_checker frame_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .mismatches      (mismatches),
    .pending         (pending),
    .bytes_taken     (bytes_taken),
    .frames_seen     (frames_seen),
    .frames_rejected (frames_rejected)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Output side: always ready, a random or fixed stall pattern, or a long hold-off
  // requested by the stimulus to back the block up.
  always @(negedge clk) begin
    rx_cyc++;
    if (hold_req) begin
      out_ch.ready <= 1'b0;
      hold_count++;
      if (hold_count >= HOLD_CYCLES) begin
        hold_count = 0;
        hold_req = 1'b0;
      end
    end else begin
      case (rx_mode)
        RX_OPEN:    out_ch.ready <= 1'b1;
        RX_RANDOM:  out_ch.ready <= ($urandom_range(0, 3) != 0);
        RX_PATTERN: out_ch.ready <= ((rx_cyc % 7) < 4);
        default:    out_ch.ready <= 1'b1;
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no request accepted for %0d cycles", IDLE_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Offers one byte, with a random gap first when the current burst is used up and not dense.
  task automatic push_byte(input byte_t b);
    int gap;
    if (!dense && burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 20);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
    bytes_offered++;
  endtask

  function automatic byte_t frame_sum(input byte_t flags, input logic [15:0] sx,
                                      input logic [15:0] sy, input logic [15:0] sz);
    return flags ^ sx[7:0] ^ sx[15:8] ^ sy[7:0] ^ sy[15:8] ^ sz[7:0] ^ sz[15:8];
  endfunction

  task automatic emit_frame(input byte_t flags, input logic [15:0] sx,
                            input logic [15:0] sy, input logic [15:0] sz,
                            input byte_t chk);
    push_byte(sync_setting);
    push_byte(flags);
    push_byte(sx[7:0]);
    push_byte(sx[15:8]);
    push_byte(sy[7:0]);
    push_byte(sy[15:8]);
    push_byte(sz[7:0]);
    push_byte(sz[15:8]);
    push_byte(chk);
  endtask

  task automatic send_random_frame(input bit good_sum);
    byte_t       flags;
    logic [15:0] s [3];
    byte_t       chk;
    int          k;
    flags = byte_t'($urandom);
    for (k = 0; k < 3; k++) begin
      case ($urandom_range(0, 9))
        0:       s[k] = 16'h0000;
        1:       s[k] = 16'hFFFF;
        2:       s[k] = {sync_setting, sync_setting};
        default: s[k] = 16'($urandom);
      endcase
    end
    chk = frame_sum(flags, s[0], s[1], s[2]);
    if (!good_sum) chk ^= byte_t'($urandom_range(1, 255));
    emit_frame(flags, s[0], s[1], s[2], chk);
  endtask

  // Mostly whole frames; the rest is line noise and frames cut short.
  task automatic run_random(input int count);
    int start;
    int pick;
    start = bytes_offered;
    while (bytes_offered - start < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        send_random_frame(pick < 66);
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 6)) push_byte(byte_t'($urandom));
      end else begin
        push_byte(sync_setting);
        repeat ($urandom_range(1, 7)) push_byte(byte_t'($urandom));
      end
    end
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    // The block may still hold a request that produces nothing.
    repeat (4) @(negedge clk);
  endtask

  task automatic write_sync(input byte_t v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    sync_setting = v;
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_data      = '0;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = '0;
    out_ch.ready  = 1'b0;
    rx_mode       = RX_OPEN;
    sync_setting  = SYNC_RESET;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: junk while hunting, a good frame with the sync value inside
    // it and all-ones and all-zero fields, then a frame with a bad checksum.
    push_byte(8'h00);
    emit_frame(8'h0F, 16'hFFFF, 16'h0000, 16'h55AA,
               frame_sum(8'h0F, 16'hFFFF, 16'h0000, 16'h55AA));
    emit_frame(8'hF0, 16'h0000, 16'hFFFF, 16'h1234,
               ~frame_sum(8'hF0, 16'h0000, 16'hFFFF, 16'h1234));
    wait_drained();

    write_sync(8'h00);
    rx_mode = RX_RANDOM;
    run_random(420);

    // Back-pressure: output held off while frames keep coming.
    dense = 1'b1;
    hold_req = 1'b1;
    while (hold_req) send_random_frame(1'b1);
    dense = 1'b0;
    wait_drained();

    // Leave a frame half done across a sync change; it must finish unaffected.
    push_byte(sync_setting);
    repeat (4) push_byte(byte_t'($urandom));
    wait_drained();
    write_sync(8'hFF);
    rx_mode = RX_PATTERN;
    run_random(420);
    wait_drained();

    random_sync = byte_t'($urandom_range(1, 254));
    write_sync(random_sync);
    rx_mode = RX_OPEN;
    run_random(420);
    wait_drained();

    write_sync(SYNC_RESET);
    rx_mode = RX_RANDOM;
    run_random(420);
    wait_drained();

    $display("Sent %0d bytes under sync values 0x00, 0xFF, 0x%02h and 0x%02h, with stalls",
             bytes_taken, random_sync, SYNC_RESET);
    $display("and a long output hold-off; %0d frames decoded, %0d with a bad checksum.",
             frames_seen, frames_rejected);
    if (mismatches == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ motion_frame_deframer_core.f @@
+incdir+rtl
rtl/mfd_pkg.sv
rtl/mfd_ifs.sv
rtl/mfd_collect.sv
rtl/mfd_outreg.sv
rtl/motion_frame_deframer_core.sv
dv/mfd_frame_checker.sv
dv/motion_frame_deframer_core_tb.sv
